@@ sv/ese_pkg.sv @@
// shared types and constants of the encoder speed estimator
`default_nettype none

package ese_pkg;

    // filter weights, new and old, over 2^WEIGHT_BITS
    localparam int WEIGHT_BITS = 16;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_NEW = 16'd6554;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_OLD = 16'd58982;

    // product magnitude clamp is 2^CLAMP_BITS
    localparam int CLAMP_BITS = 40;

    // reset value of counts_per_rev
    localparam logic [15:0] CPR_RESET = 16'd4096;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_REV    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_SPEED_FACTOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_SPEED_CONST   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD     = 3'd4;

    // operand select of the shared weight multiplier
    typedef enum logic [1:0] {
        MUL_RAW,
        MUL_SF,
        MUL_PROD,
        MUL_SPEED
    } t_mul_sel;

    typedef struct packed {
        logic     accept;
        logic     div_step;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     fac_upd;
        logic     prod_en;
        logic     fin;
    } t_dp_cmd;

    typedef struct packed {
        logic use_low;
        logic pulse_zero;
    } t_dp_status;

endpackage

`default_nettype wire

@@ sv/ese_in_if.sv @@
// input channel of the encoder speed estimator
`default_nettype none

interface ese_in_if #(
    parameter int COUNTER_BITS = 16
) ();
    logic                    valid;
    logic                    ready;
    logic [COUNTER_BITS-1:0] encoder_count;
    logic [31:0]             pulse_count;
    logic signed [31:0]      target_speed;

    modport source (
        output valid, encoder_count, pulse_count, target_speed,
        input  ready
    );
    modport sink (
        input  valid, encoder_count, pulse_count, target_speed,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/ese_out_if.sv @@
// result channel of the encoder speed estimator
`default_nettype none

interface ese_out_if ();
    logic               valid;
    logic               ready;
    logic signed [31:0] speed;
    logic               low_speed_mode;

    modport source (
        output valid, speed, low_speed_mode,
        input  ready
    );
    modport sink (
        input  valid, speed, low_speed_mode,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/ese_ctrl.sv @@
// sequencing controller of the encoder speed estimator
`default_nettype none

module ese_ctrl
    import ese_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_dp_cmd         o_cmd,
    input  wire t_dp_status i_status
);

    localparam int DIV_STEPS = 32 + FRACTION_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_MUL_RAW,
        S_MUL_SF,
        S_FAC,
        S_PROD,
        S_MUL_PROD,
        S_MUL_SPEED,
        S_FIN
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_RAW;
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_out_valid   = r_out_valid & ~i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_cnt        = CNT_W'(DIV_STEPS - 1);
                    n_state      = i_status.use_low ? S_DIV : S_PROD;
                end
            end
            S_DIV: begin
                if (i_status.pulse_zero) begin
                    n_state = S_MUL_RAW;
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (r_cnt == '0) begin
                        n_state = S_MUL_RAW;
                    end else begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end
            end
            S_MUL_RAW: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_RAW;
                n_state       = S_MUL_SF;
            end
            S_MUL_SF: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SF;
                n_state       = S_FAC;
            end
            S_FAC: begin
                o_cmd.fac_upd = 1'b1;
                n_state       = S_PROD;
            end
            S_PROD: begin
                o_cmd.prod_en = 1'b1;
                n_state       = S_MUL_PROD;
            end
            S_MUL_PROD: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_PROD;
                n_state       = S_MUL_SPEED;
            end
            S_MUL_SPEED: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SPEED;
                n_state       = S_FIN;
            end
            S_FIN: begin
                // result register must be free before the state updates
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.fin   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ sv/ese_datapath.sv @@
// datapath of the encoder speed estimator: registers, divider, multipliers
`default_nettype none

module ese_datapath
    import ese_pkg::*;
#(
    parameter int COUNTER_BITS  = 16,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_dp_cmd                       i_cmd,
    output t_dp_status                         o_status,
    input  wire logic [COUNTER_BITS-1:0]       i_encoder_count,
    input  wire logic [31:0]                   i_pulse_count,
    input  wire logic signed [31:0]            i_target_speed,
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [32+FRACTION_BITS-1:0]   i_cfg_data,
    output logic signed [31:0]                 o_speed,
    output logic                               o_low_speed_mode
);

    localparam int LSC_W   = 32 + FRACTION_BITS;
    localparam int DIFF_W  = COUNTER_BITS + 1;
    localparam int CMP_W   = (COUNTER_BITS + 2 > 16) ? COUNTER_BITS + 2 : 16;
    localparam int PROD_W  = DIFF_W + 32;
    localparam int CLAMP_W = CLAMP_BITS + 1;
    localparam int MOP_W   = CLAMP_W + 1;
    localparam int WOP_W   = WEIGHT_BITS + 1;
    localparam int MRES_W  = MOP_W + WOP_W;

    localparam logic [CLAMP_W-1:0] CLAMP_VAL = {1'b1, {CLAMP_BITS{1'b0}}};
    localparam logic signed [MRES_W-1:0] SPD_MAX = {{(MRES_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [MRES_W-1:0] SPD_MIN = {{(MRES_W-31){1'b1}}, {31{1'b0}}};

    // configuration
    logic [15:0]       r_cpr;
    logic [31:0]       r_hsf;
    logic [LSC_W-1:0]  r_lsc;
    logic [30:0]       r_hth;
    logic [30:0]       r_lth;

    // estimator state
    logic [COUNTER_BITS-1:0]   r_prev;
    logic signed [DIFF_W-1:0]  r_held;
    logic [31:0]               r_sf;
    logic signed [31:0]        r_speed;
    logic                      r_mode_low;
    logic                      r_low_out;

    // per-sample working registers
    logic [31:0]               r_tmag;
    logic [31:0]               r_rem;
    logic [LSC_W-1:0]          r_quo;
    logic [31:0]               r_div;
    logic signed [MRES_W-1:0]  r_pa;
    logic signed [MRES_W-1:0]  r_pb;
    logic [PROD_W-1:0]         r_prod;

    logic signed [DIFF_W-1:0]  diff;
    logic signed [CMP_W-1:0]   diff_x;
    logic signed [CMP_W-1:0]   quarter_x;
    logic                      diff_ok;
    logic [31:0]               tmag;
    logic [32:0]               rem_sh;
    logic                      div_ge;
    logic [32:0]               rem_sub;
    logic [31:0]               raw;
    logic [CLAMP_W-1:0]        prod_c;
    logic signed [MOP_W-1:0]   mop;
    logic signed [WOP_W-1:0]   wop;
    logic signed [MRES_W-1:0]  mres;
    logic [MRES_W-1:0]         sum_f;
    logic [DIFF_W-1:0]         mag;
    logic [31:0]               factor;
    logic signed [MRES_W-1:0]  signed_a;
    logic signed [MRES_W-1:0]  acc;
    logic signed [MRES_W-1:0]  acc_sh;
    logic signed [31:0]        speed_sat;

    // count difference and quarter-turn window
    always_comb begin
        diff      = $signed({1'b0, i_encoder_count}) - $signed({1'b0, r_prev});
        diff_x    = {{(CMP_W-DIFF_W){diff[DIFF_W-1]}}, diff};
        quarter_x = {{(CMP_W-14){1'b0}}, r_cpr[15:2]};
        diff_ok   = (diff_x > -quarter_x) && (diff_x < quarter_x);
        tmag      = i_target_speed[31] ? (~i_target_speed + 32'd1) : i_target_speed;
    end

    // restoring divider, one quotient bit per step
    always_comb begin
        rem_sh  = {r_rem, r_quo[LSC_W-1]};
        div_ge  = (rem_sh >= {1'b0, r_div});
        rem_sub = rem_sh - {1'b0, r_div};
        raw     = ((r_div == '0) || (|r_quo[LSC_W-1:32])) ? '1 : r_quo[31:0];
    end

    // shared weight multiplier
    always_comb begin
        prod_c = (r_prod > PROD_W'(CLAMP_VAL)) ? CLAMP_VAL : r_prod[CLAMP_W-1:0];
        case (i_cmd.mul_sel)
            MUL_RAW:   mop = {{(MOP_W-32){1'b0}}, raw};
            MUL_SF:    mop = {{(MOP_W-32){1'b0}}, r_sf};
            MUL_PROD:  mop = {1'b0, prod_c};
            MUL_SPEED: mop = {{(MOP_W-32){r_speed[31]}}, r_speed};
            default:   mop = '0;
        endcase
        if (i_cmd.mul_sel == MUL_RAW || i_cmd.mul_sel == MUL_PROD) begin
            wop = {1'b0, WEIGHT_NEW};
        end else begin
            wop = {1'b0, WEIGHT_OLD};
        end
        mres = mop * wop;
    end

    // factor filter, count-times-factor product and speed filter
    always_comb begin
        sum_f    = r_pa + r_pb;
        mag      = r_held[DIFF_W-1] ? DIFF_W'(-r_held) : r_held;
        factor   = r_mode_low ? r_sf : r_hsf;
        signed_a = r_held[DIFF_W-1] ? -r_pa : r_pa;
        acc      = signed_a + r_pb;
        acc_sh   = acc >>> WEIGHT_BITS;
        if (acc_sh > SPD_MAX) begin
            speed_sat = SPD_MAX[31:0];
        end else if (acc_sh < SPD_MIN) begin
            speed_sat = SPD_MIN[31:0];
        end else begin
            speed_sat = acc_sh[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpr      <= CPR_RESET;
            r_hsf      <= '0;
            r_lsc      <= '0;
            r_hth      <= '0;
            r_lth      <= '0;
            r_prev     <= '0;
            r_held     <= '0;
            r_sf       <= '0;
            r_speed    <= '0;
            r_mode_low <= 1'b1;
            r_low_out  <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_COUNTS_PER_REV:    r_cpr <= i_cfg_data[15:0];
                    CFG_HIGH_SPEED_FACTOR: r_hsf <= i_cfg_data[31:0];
                    CFG_LOW_SPEED_CONST:   r_lsc <= i_cfg_data[LSC_W-1:0];
                    CFG_HIGH_THRESHOLD:    r_hth <= i_cfg_data[30:0];
                    CFG_LOW_THRESHOLD:     r_lth <= i_cfg_data[30:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.accept) begin
                r_prev <= i_encoder_count;
                if (diff_ok) begin
                    r_held <= diff;
                end
            end
            if (i_cmd.fac_upd) begin
                r_sf <= sum_f[WEIGHT_BITS +: 32];
            end
            if (i_cmd.fin) begin
                r_speed   <= speed_sat;
                r_low_out <= r_mode_low;
                if (r_mode_low) begin
                    if (r_tmag > {1'b0, r_hth}) begin
                        r_mode_low <= 1'b0;
                    end
                end else begin
                    if (r_tmag < {1'b0, r_lth}) begin
                        r_mode_low <= 1'b1;
                    end
                end
            end
        end
    end

    // working registers need no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tmag <= tmag;
            r_rem  <= '0;
            r_quo  <= r_lsc;
            r_div  <= i_pulse_count;
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? rem_sub[31:0] : rem_sh[31:0];
            r_quo <= {r_quo[LSC_W-2:0], div_ge};
        end
        if (i_cmd.mul_en) begin
            if (i_cmd.mul_sel == MUL_RAW || i_cmd.mul_sel == MUL_PROD) begin
                r_pa <= mres;
            end else begin
                r_pb <= mres;
            end
        end
        if (i_cmd.prod_en) begin
            r_prod <= {32'd0, mag} * {{DIFF_W{1'b0}}, factor};
        end
    end

    assign o_status.use_low    = r_mode_low;
    assign o_status.pulse_zero = (r_div == '0);
    assign o_speed             = r_speed;
    assign o_low_speed_mode    = r_low_out;

endmodule

`default_nettype wire

@@ sv/encoder_speed_estimator.sv @@
// sequence per input beat: in low-speed mode a bit-serial divide of 48 steps at default
// widths (32+FRACTION_BITS in general), skipped on a zero pulse count, then the factor
// filter, product and speed filter; high-speed mode skips the divide and factor filter.
// throughput: one item at a time, next beat taken on return to idle even while the result
// beat still waits.
// reset: synchronous active low; state cleared, low-speed mode, counts_per_rev 4096.
`default_nettype none

module encoder_speed_estimator
    import ese_pkg::*;
#(
    parameter int COUNTER_BITS  = 16,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    ese_in_if.sink                           i_in,
    ese_out_if.source                        o_out,
    input  wire logic                        i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [32+FRACTION_BITS-1:0] i_cfg_data
);

    // command and status between sequencer and datapath
    t_dp_cmd    cmd;
    t_dp_status status;

    logic in_ready;
    logic out_valid;

    // sequencer: idle, divide, factor filter, product, speed filter, result
    ese_ctrl #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // datapath: config registers, estimator state, divider, multipliers
    // the speed state register doubles as the result payload register,
    // it only changes when the result beat has been taken
    ese_datapath #(
        .COUNTER_BITS  (COUNTER_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_encoder_count  (i_in.encoder_count),
        .i_pulse_count    (i_in.pulse_count),
        .i_target_speed   (i_in.target_speed),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_speed          (o_out.speed),
        .o_low_speed_mode (o_out.low_speed_mode)
    );

    // handshake outputs
    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule

`default_nettype wire

@@ sv/ese_checker.sv @@
// port-level assertions of the encoder speed estimator and their bind
`default_nettype none

module ese_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_speed,
    input wire logic        i_low_speed_mode
);

    // after reset the block is idle with no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (i_in_ready && !i_out_valid))
        else $error("not idle after reset");

    // one item at a time: an accepted beat closes the input
    a_one_at_a_time: assert property (@(posedge i_clk)
        (i_rst_n && i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input accepted while busy");

    // a new result only appears at the end of a busy period
    a_result_from_work: assert property (@(posedge i_clk)
        (i_rst_n && $rose(i_out_valid)) |-> !$past(i_in_ready))
        else $error("result without work");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk)
        (i_rst_n && i_out_valid && !i_out_ready) |=>
            (!i_rst_n || (i_out_valid && $stable(i_speed) && $stable(i_low_speed_mode))))
        else $error("stalled result changed");

endmodule

bind encoder_speed_estimator ese_checker u_ese_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_speed          (o_out.speed),
    .i_low_speed_mode (o_out.low_speed_mode)
);

`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench of the encoder speed estimator: directed table, then random phases
module tb;
    import ese_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 8;
    // longest pass through the block is the low-speed mode one with the divide
    localparam int SETTLE_CYCLES   = 64;
    // slowest run is about 2000 beats, taken several times over
    localparam int LIMIT_CYCLES    = 2_000_000;
    localparam int NUM_PHASES      = 10;
    localparam int BEATS_PER_PHASE = 193;

    // an index past the register list, the block must ignore it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    // filter weights over 2^16 and the product magnitude clamp
    localparam longint          WT_NEW     = 6554;
    localparam longint          WT_OLD     = 58982;
    localparam longint unsigned PROD_LIMIT = 64'd1 << 40;
    localparam longint unsigned FACTOR_MAX = 64'hFFFF_FFFF;

    typedef enum {ROW_WRITE, ROW_SAMPLE} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [47:0]           val;
        logic [15:0]           enc;
        logic [31:0]           pulses;
        logic signed [31:0]    tgt;
        bit                    typed;     // expected result given in the table
        logic signed [31:0]    speed;
        bit                    low_mode;
    } t_stim_row;

    typedef struct {
        logic signed [31:0] speed;
        logic               low_mode;
    } t_speed_result;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [47:0]          cfg_data;

    ese_in_if #(.COUNTER_BITS(16)) in_ch ();
    ese_out_if                     out_ch ();

    encoder_speed_estimator #(
        .COUNTER_BITS  (16),
        .FRACTION_BITS (16)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // register mirror
    logic [15:0] cfg_cpr;
    logic [31:0] cfg_hs_factor;
    logic [47:0] cfg_ls_const;
    logic [30:0] cfg_hi_thr;
    logic [30:0] cfg_lo_thr;

    // estimator state as the block should hold it
    logic [15:0]        last_count;
    longint             kept_diff;
    logic [31:0]        factor_avg;
    logic signed [31:0] speed_avg;
    bit                 in_low_mode;

    t_speed_result pending_speeds[$];
    t_stim_row     dir_rows[$];

    int fails = 0;
    int src_idle_pct;
    int snk_idle_pct;
    int stall_left = 0;

    always begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_idle(int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // one control tick of the estimator: updates the state, returns the result beat
    function automatic t_speed_result estimate_speed(logic [15:0] enc, logic [31:0] pulses,
                                                     logic signed [31:0] tgt);
        t_speed_result      res;
        longint             enc_now, enc_old, diff, quarter, acc, tmag;
        longint unsigned    raw, factor, mag, prod;
        bit                 used_low;
        used_low = in_low_mode;

        // count difference, accepted only strictly inside a quarter turn
        enc_now = enc;
        enc_old = last_count;
        diff    = enc_now - enc_old;
        quarter = cfg_cpr >> 2;
        if (diff > -quarter && diff < quarter) kept_diff = diff;
        last_count = enc;

        // magnitude of the target, most negative value gives 2^31
        tmag = longint'(tgt);
        if (tmag < 0) tmag = -tmag;

        if (used_low) begin
            if (pulses == 32'd0) begin
                raw = FACTOR_MAX;
            end else begin
                raw = longint'(cfg_ls_const) / longint'(pulses);
                if (raw > FACTOR_MAX) raw = FACTOR_MAX;
            end
            factor_avg = 32'((raw * WT_NEW + longint'(factor_avg) * WT_OLD) >> 16);
            factor     = factor_avg;
        end else begin
            factor = cfg_hs_factor;
        end

        // product magnitude clamped before weighting, the sign goes on afterwards
        mag = (kept_diff < 0) ? -kept_diff : kept_diff;
        if (mag != 0 && factor > PROD_LIMIT / mag) begin
            prod = PROD_LIMIT;
        end else begin
            prod = mag * factor;
            if (prod > PROD_LIMIT) prod = PROD_LIMIT;
        end
        acc = prod * WT_NEW;
        if (kept_diff < 0) acc = -acc;
        acc = acc + longint'(speed_avg) * WT_OLD;
        acc = acc >>> 16;
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        speed_avg = 32'(acc);

        // hysteresis on the target magnitude, takes effect from the next tick
        if (used_low) begin
            if (tmag > longint'(cfg_hi_thr)) in_low_mode = 1'b0;
        end else begin
            if (tmag < longint'(cfg_lo_thr)) in_low_mode = 1'b1;
        end

        res.speed    = speed_avg;
        res.low_mode = used_low;
        return res;
    endfunction

    function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [47:0] val);
        t_stim_row row;
        row       = '{kind: ROW_WRITE, default: 0};
        row.idx   = idx;
        row.val   = val;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_sample(logic [15:0] enc, logic [31:0] pulses,
                                       logic signed [31:0] tgt, bit typed = 1'b0,
                                       logic signed [31:0] speed = 32'sd0, bit low_mode = 1'b0);
        t_stim_row row;
        row          = '{kind: ROW_SAMPLE, default: 0};
        row.enc      = enc;
        row.pulses   = pulses;
        row.tgt      = tgt;
        row.typed    = typed;
        row.speed    = speed;
        row.low_mode = low_mode;
        dir_rows.push_back(row);
    endfunction

    // register write, then the mirror follows; the block is idle here
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_COUNTS_PER_REV:    cfg_cpr       = val[15:0];
            CFG_HIGH_SPEED_FACTOR: cfg_hs_factor = val[31:0];
            CFG_LOW_SPEED_CONST:   cfg_ls_const  = val;
            CFG_HIGH_THRESHOLD:    cfg_hi_thr    = val[30:0];
            CFG_LOW_THRESHOLD:     cfg_lo_thr    = val[30:0];
            default: ;
        endcase
    endtask

    // one input beat; the expectation is queued at the accepting edge
    task automatic feed_sample(logic [15:0] enc, logic [31:0] pulses, logic signed [31:0] tgt,
                               bit typed, logic signed [31:0] t_speed, bit t_low);
        int            gap;
        t_speed_result got;
        gap = pick_idle(src_idle_pct);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.encoder_count <= enc;
        in_ch.pulse_count   <= pulses;
        in_ch.target_speed  <= tgt;
        do @(posedge clk); while (!in_ch.ready);
        got = estimate_speed(enc, pulses, tgt);
        if (typed) begin
            got.speed    = t_speed;
            got.low_mode = t_low;
        end
        pending_speeds.push_back(got);
    endtask

    // wait for every result, then let the block run out
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending_speeds.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result side: check the beat seen at this edge, then decide on ready
    always @(posedge clk) begin : result_side
        t_speed_result want;
        int            gap;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_speeds.size() == 0) begin
                $error("result beat with nothing expected: speed %0d low_speed_mode %0b",
                       out_ch.speed, out_ch.low_speed_mode);
                fails++;
            end else begin
                want = pending_speeds.pop_front();
                if (out_ch.speed !== want.speed) begin
                    $error("speed: expected %0d, got %0d", want.speed, out_ch.speed);
                    fails++;
                end
                if (out_ch.low_speed_mode !== want.low_mode) begin
                    $error("low_speed_mode: expected %0b, got %0b",
                           want.low_mode, out_ch.low_speed_mode);
                    fails++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else begin
            gap = pick_idle(snk_idle_pct);
            if (gap > 0) begin
                stall_left = gap - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $error("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_speeds.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        t_stim_row          row;
        logic [15:0]        cpr;
        logic [31:0]        hsf;
        logic [47:0]        lsc;
        logic [30:0]        hthr, lthr;
        logic [15:0]        enc_pos;
        logic [31:0]        pulses;
        logic signed [31:0] tgt;
        longint             tm;
        int                 q, span, lim, step, pick;

        src_idle_pct = 30;
        snk_idle_pct = 30;

        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= '0;
        cfg_data            <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.encoder_count <= '0;
        in_ch.pulse_count   <= '0;
        in_ch.target_speed  <= '0;

        // state after reset
        cfg_cpr       = CPR_RESET;
        cfg_hs_factor = '0;
        cfg_ls_const  = '0;
        cfg_hi_thr    = '0;
        cfg_lo_thr    = '0;
        last_count    = '0;
        kept_diff     = 0;
        factor_avg    = '0;
        speed_avg     = '0;
        in_low_mode   = 1'b1;

        // directed table
        // after reset every register but counts_per_rev is zero and the block is in low-speed mode
        add_sample(16'd0, 32'd1, 32'sd0, 1'b1, 32'sd0, 1'b1);
        // zero pulse count saturates the factor, the difference is still zero
        add_sample(16'd0, 32'd0, 32'sd0, 1'b1, 32'sd0, 1'b1);
        // any target above a zero threshold leaves low-speed mode after this tick
        add_sample(16'd0, 32'hFFFF_FFFF, 32'sd1, 1'b1, 32'sd0, 1'b1);
        add_sample(16'd0, 32'd5, 32'sd0, 1'b1, 32'sd0, 1'b0);
        // every register at its top value; the spare index must change nothing
        add_write(CFG_COUNTS_PER_REV, 48'hFFFF);
        add_write(CFG_HIGH_SPEED_FACTOR, 48'hFFFF_FFFF);
        add_write(CFG_LOW_SPEED_CONST, 48'hFFFF_FFFF_FFFF);
        add_write(CFG_HIGH_THRESHOLD, 48'h7FFF_FFFF);
        add_write(CFG_LOW_THRESHOLD, 48'h7FFF_FFFF);
        add_write(CFG_SPARE, 48'd0);
        // clamped product overflows upward; most negative target keeps high mode
        add_sample(16'd16000, 32'd1, 32'sh8000_0000, 1'b1, 32'sh7FFF_FFFF, 1'b0);
        // same jump back overflows downward; zero target drops to low mode
        add_sample(16'd0, 32'd1, 32'sd0, 1'b1, 32'sh8000_0000, 1'b0);
        // top constant over one pulse saturates the low-mode factor
        add_sample(16'd0, 32'd1, 32'sh7FFF_FFFF);
        // counter wrap in both directions, the held difference is kept
        add_sample(16'hFFFF, 32'h0001_2345, 32'sh7FFF_FFFF);
        add_sample(16'd0, 32'd2, 32'sd0);
        // counts per rev below four: the quarter limit is zero
        add_write(CFG_COUNTS_PER_REV, 48'd3);
        add_write(CFG_HIGH_THRESHOLD, 48'd0);
        add_write(CFG_LOW_THRESHOLD, 48'd0);
        add_sample(16'd1, 32'd1000, -32'sd1);
        add_write(CFG_COUNTS_PER_REV, 48'd1);
        add_sample(16'd2, 32'd7, 32'sd0);
        // quarter limit of one lets only a zero difference through
        add_write(CFG_COUNTS_PER_REV, 48'd4);
        add_write(CFG_HIGH_SPEED_FACTOR, 48'h1_0000);
        add_write(CFG_LOW_SPEED_CONST, 48'h1_0000_0000);
        add_sample(16'd2, 32'd9, 32'sd0);
        add_sample(16'd3, 32'd9, 32'sd0);
        // ordinary setting with a hysteresis band of 50 to 100
        add_write(CFG_COUNTS_PER_REV, 48'd4096);
        add_write(CFG_HIGH_SPEED_FACTOR, 48'h2_0000);
        add_write(CFG_LOW_SPEED_CONST, 48'd1000 << 16);
        add_write(CFG_HIGH_THRESHOLD, 48'd100 << 16);
        add_write(CFG_LOW_THRESHOLD, 48'd50 << 16);
        add_sample(16'd10, 32'd100, 32'sd60 <<< 16);
        add_sample(16'd20, 32'd100, 32'sd40 <<< 16);
        add_sample(16'd30, 32'd50, -(32'sd120 <<< 16));
        add_sample(16'd20, 32'd50, 32'sd0);
        add_sample(16'd25, 32'd0, 32'sh8000_0000);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.kind == ROW_WRITE) begin
                settle();
                write_reg(row.idx, row.val);
            end else begin
                feed_sample(row.enc, row.pulses, row.tgt, row.typed, row.speed, row.low_mode);
            end
        end

        // random phases, each under its own register setting
        enc_pos = last_count;
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            if (p == 0) begin
                cpr  = 16'hFFFF;
                hsf  = 32'hFFFF_FFFF;
                lsc  = 48'hFFFF_FFFF_FFFF;
                hthr = 31'h7FFF_FFFF;
                lthr = 31'h7FFF_FFFF;
            end else if (p == 1) begin
                cpr  = 16'd1;
                hsf  = '0;
                lsc  = '0;
                hthr = '0;
                lthr = '0;
            end else begin
                pick = $urandom_range(0, 9);
                if (pick == 0)      cpr = 16'($urandom_range(1, 3));
                else if (pick == 1) cpr = 16'hFFFF;
                else if (pick < 4)  cpr = 16'd4096;
                else                cpr = 16'($urandom_range(4, 65535));
                hsf  = $urandom >> $urandom_range(0, 31);
                lsc  = {16'($urandom_range(0, 65535)), $urandom} >> $urandom_range(0, 47);
                hthr = 31'($urandom >> $urandom_range(1, 31));
                // usually a proper band, sometimes an inverted one
                lthr = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                   : hthr >> $urandom_range(0, 3);
            end
            write_reg(CFG_COUNTS_PER_REV, 48'(cpr));
            write_reg(CFG_HIGH_SPEED_FACTOR, 48'(hsf));
            write_reg(CFG_LOW_SPEED_CONST, lsc);
            write_reg(CFG_HIGH_THRESHOLD, 48'(hthr));
            write_reg(CFG_LOW_THRESHOLD, 48'(lthr));
            if (p == 2) write_reg(CFG_SPARE, {16'($urandom), $urandom});

            // some phases run without any idling on one side or the other
            src_idle_pct = (p % 3 == 0) ? 0 : 35;
            snk_idle_pct = (p % 4 == 1) ? 0 : 35;

            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                // encoder: mostly moves inside the quarter turn, some jumps and noise
                q    = cfg_cpr >> 2;
                span = (q > 0) ? q - 1 : 0;
                pick = $urandom_range(0, 99);
                if (pick < 7) begin
                    enc_pos = 16'($urandom);
                end else if (pick < 12) begin
                    enc_pos = enc_pos + 16'(q + $urandom_range(0, 64));
                end else begin
                    lim  = ($urandom_range(0, 3) == 0 || span < 24) ? span : 24;
                    step = int'($urandom_range(0, 2 * lim)) - lim;
                    enc_pos = enc_pos + 16'(step);
                end

                pick = $urandom_range(0, 99);
                if (pick < 5)       pulses = 32'd0;
                else if (pick < 15) pulses = $urandom;
                else if (pick < 30) pulses = $urandom_range(1, 16);
                else                pulses = $urandom_range(17, 200000);

                // target: mostly near one of the thresholds, either sign
                pick = $urandom_range(0, 99);
                if (pick < 6) begin
                    tgt = $urandom;
                end else if (pick < 9) begin
                    tgt = 32'sh8000_0000;
                end else begin
                    tm = ($urandom_range(0, 1) != 0) ? longint'(cfg_hi_thr)
                                                     : longint'(cfg_lo_thr);
                    tm = tm + longint'($urandom_range(0, 6)) - 3;
                    if ($urandom_range(0, 4) == 0) tm = $urandom_range(0, 32'h7FFF_FFFF);
                    if (tm < 0) tm = 0;
                    tgt = ($urandom_range(0, 1) != 0) ? 32'(-tm) : 32'(tm);
                end

                feed_sample(enc_pos, pulses, tgt, 1'b0, 32'sd0, 1'b0);
            end
        end

        settle();
        if (fails == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/ese_pkg.sv
sv/ese_in_if.sv
sv/ese_out_if.sv
sv/ese_ctrl.sv
sv/ese_datapath.sv
sv/encoder_speed_estimator.sv
sv/ese_checker.sv
tb/tb.sv
